// ===== rtl/dhe_pkg.sv =====
`default_nettype none

package dhe_pkg;

    // Bin store geometry
    localparam int BINS    = 16384;
    localparam int BIN_AW  = $clog2(BINS);
    localparam int CNT_W   = 19;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Pixel fields
    localparam int DEPTH_W = 16;
    localparam int GREY_W  = 8;
    localparam int BGRA_W  = 32;
    localparam logic [GREY_W-1:0] ALPHA_FULL = 8'hFF;

    // Request codes
    localparam logic REQ_HIST = 1'b0;
    localparam logic REQ_MAP  = 1'b1;

    // Configuration
    localparam int MD_W    = 15;
    localparam logic [MD_W-1:0] MD_RESET = 15'd10000;
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 3;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_BIN_LIMIT = 1'b0;

    // Fraction divider: one quotient bit per step
    localparam int DIV_STEPS = GREY_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] num;
        logic [CNT_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [GREY_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== rtl/dhe_in_if.sv =====
`default_nettype none

interface dhe_in_if import dhe_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [DEPTH_W-1:0] depth;
    logic               last;

    modport source (output valid, output req_type, output depth, output last, input ready);
    modport sink   (input valid, input req_type, input depth, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/dhe_out_if.sv =====
`default_nettype none

interface dhe_out_if import dhe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BGRA_W-1:0] pixel_bgra;
    logic              last_pixel;

    modport source (output valid, output pixel_bgra, output last_pixel, input ready);
    modport sink   (input valid, input pixel_bgra, input last_pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/depth_histogram_equalizer_core.sv =====
`default_nettype none

// Channel  | Dir | Beat content                | Handshake
// i_pix    | in  | req_type, depth, last       | valid/ready
// o_pix    | out | pixel_bgra, last_pixel      | valid/ready
// APB      | in  | bin limit at byte address 0 | psel/penable, pready tied high
//
// Histogram beat: a bin store read and write, only the read for a zero depth; the
// first beat of a pass adds a sweep that zeroes the bin store. The last beat adds a
// running sum over bins 1 to m-1 and, when points were counted, a table build over bins 1 to m-1,
// m being the bins in use; each table entry is one pass of the 8-step fraction divider.
// Mapping beat: one bin store read. After reset a sweep clears the store before
// the first beat is taken. i_pix.ready is low while a beat is at work; a finished
// pixel waits in the output register.
module depth_histogram_equalizer_core import dhe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dhe_in_if.sink             i_pix,
    dhe_out_if.source          o_pix,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_H_RD  = 4'd2;
    localparam logic [3:0] S_H_WR  = 4'd3;
    localparam logic [3:0] S_P_RD  = 4'd4;
    localparam logic [3:0] S_P_WR  = 4'd5;
    localparam logic [3:0] S_T_RD  = 4'd6;
    localparam logic [3:0] S_T_LD  = 4'd7;
    localparam logic [3:0] S_T_DIV = 4'd8;
    localparam logic [3:0] S_M_RD  = 4'd9;
    localparam logic [3:0] S_M_OUT = 4'd10;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
    endfunction

    logic [3:0]        r_state,     n_state;
    logic [BIN_AW-1:0] r_idx,       n_idx;
    logic              r_after_clr, n_after_clr;
    logic              r_pass,      n_pass;
    logic [CNT_W-1:0]  r_n,         n_n;
    logic [CNT_W-1:0]  r_sum,       n_sum;
    logic [BIN_AW-1:0] r_d,         n_d;
    logic              r_last,      n_last;
    logic [BIN_AW-1:0] r_mlast,     n_mlast;
    logic [MD_W-1:0]   r_md;
    logic              r_ov;
    logic [GREY_W-1:0] r_grey;
    logic              r_olast;

    logic [MD_W-1:0]   used_m;
    logic [BIN_AW-1:0] mlast;
    logic [BIN_AW-1:0] clamp_d;

    logic              ram_we;
    logic [BIN_AW-1:0] ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [BIN_AW-1:0] ram_raddr;
    logic [CNT_W-1:0]  ram_rdata;

    logic [CNT_W-1:0]  add_b;
    logic [CNT_W-1:0]  add_s;
    logic [CNT_W-1:0]  tab_c;
    logic              out_free;
    logic              out_load;
    logic [3:0]        after_hist;
    logic              cfg_wr;

    t_div_req          div_req;
    t_div_rsp          div_rsp;

    // Configuration register
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[PADDR_W-1 -: REG_IDX_W] == REG_BIN_LIMIT);
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1 -: REG_IDX_W] == REG_BIN_LIMIT)
                    ? APB_DW'(r_md) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_md <= MD_RESET;
        end else if (cfg_wr) begin
            r_md <= pwdata[MD_W-1:0];
        end
    end

    // Bins in use and depth clamp
    always_comb begin
        if (r_md == '0) begin
            used_m = MD_W'(1);
        end else if (r_md > MD_W'(BINS)) begin
            used_m = MD_W'(BINS);
        end else begin
            used_m = r_md;
        end
        mlast   = BIN_AW'(used_m - MD_W'(1));
        clamp_d = (i_pix.depth >= DEPTH_W'(used_m)) ? mlast : i_pix.depth[BIN_AW-1:0];
    end

    // Shared saturating adder: +1 for a histogram beat, +running sum in the prefix pass
    assign add_b = (r_state == S_P_WR) ? r_sum : CNT_W'(1);
    assign add_s = sat_add(ram_rdata, add_b);

    // Table entry: c clipped to n
    assign tab_c = (ram_rdata > r_n) ? r_n : ram_rdata;

    assign out_free = !r_ov || o_pix.ready;
    assign out_load = (r_state == S_M_OUT) && out_free;

    // Where a histogram beat goes once counted
    assign after_hist = (r_last && (r_mlast != '0)) ? S_P_RD : S_IDLE;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_after_clr = r_after_clr;
        n_pass      = r_pass;
        n_n         = r_n;
        n_sum       = r_sum;
        n_d         = r_d;
        n_last      = r_last;
        n_mlast     = r_mlast;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_idx;
        div_req.start = 1'b0;
        div_req.num   = r_n - tab_c;
        div_req.den   = r_n;

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_idx == {BIN_AW{1'b1}}) begin
                    n_idx   = '0;
                    n_state = r_after_clr ? S_H_RD : S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_pix.valid) begin
                    n_d     = clamp_d;
                    n_last  = i_pix.last;
                    n_mlast = mlast;
                    if (i_pix.req_type == REQ_MAP) begin
                        n_state = S_M_RD;
                    end else if (!r_pass) begin
                        n_pass      = 1'b1;
                        n_n         = '0;
                        n_idx       = '0;
                        n_after_clr = 1'b1;
                        n_state     = S_CLEAR;
                    end else begin
                        n_state = S_H_RD;
                    end
                end
            end
            S_H_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_d;
                if (r_d != '0) begin
                    n_state = S_H_WR;
                end else begin
                    n_state = after_hist;
                    n_idx   = BIN_AW'(1);
                    n_sum   = '0;
                    if (r_last) begin
                        n_pass = 1'b0;
                    end
                end
            end
            S_H_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_d;
                ram_wdata = add_s;
                n_n       = sat_add(r_n, CNT_W'(1));
                n_state   = after_hist;
                n_idx     = BIN_AW'(1);
                n_sum     = '0;
                if (r_last) begin
                    n_pass = 1'b0;
                end
            end
            S_P_RD: begin
                ram_re  = 1'b1;
                n_state = S_P_WR;
            end
            S_P_WR: begin
                ram_we    = 1'b1;
                ram_wdata = add_s;
                n_sum     = add_s;
                if (r_idx == r_mlast) begin
                    if (r_n == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = BIN_AW'(1);
                        n_state = S_T_RD;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_P_RD;
                end
            end
            S_T_RD: begin
                ram_re  = 1'b1;
                n_state = S_T_LD;
            end
            S_T_LD: begin
                div_req.start = 1'b1;
                n_state       = S_T_DIV;
            end
            S_T_DIV: begin
                if (div_rsp.done) begin
                    ram_we    = 1'b1;
                    ram_wdata = CNT_W'(div_rsp.quot);
                    if (r_idx == r_mlast) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_T_RD;
                    end
                end
            end
            S_M_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_d;
                n_state   = S_M_OUT;
            end
            S_M_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_after_clr <= 1'b0;
            r_pass      <= 1'b0;
            r_n         <= '0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_after_clr <= n_after_clr;
            r_pass      <= n_pass;
            r_n         <= n_n;
        end
    end

    // Beat payload and running sum
    always_ff @(posedge i_clk) begin
        r_sum   <= n_sum;
        r_d     <= n_d;
        r_last  <= n_last;
        r_mlast <= n_mlast;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_pix.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_grey  <= (r_d == '0) ? '0 : ram_rdata[GREY_W-1:0];
            r_olast <= r_last;
        end
    end

    assign i_pix.ready      = (r_state == S_IDLE);
    assign o_pix.valid      = r_ov;
    assign o_pix.pixel_bgra = {ALPHA_FULL, r_grey, r_grey, r_grey};
    assign o_pix.last_pixel = r_olast;

    // Bin store
    dhe_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Grey fraction divider
    dhe_frac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/dhe_ram.sv =====
`default_nettype none

module dhe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds without i_re
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/dhe_frac_div.sv =====
`default_nettype none

// floor(2^GREY_W * num / den) for num <= den, saturated to all ones.
module dhe_frac_div import dhe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic              r_sat;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_den;
    logic [GREY_W-1:0] r_quo;

    logic [CNT_W:0]    step_t;
    logic              step_ge;
    logic [CNT_W:0]    step_r;

    // Restoring step: shift remainder, compare, subtract
    always_comb begin
        step_t  = {r_rem, 1'b0};
        step_ge = (step_t >= {1'b0, r_den});
        step_r  = step_ge ? (step_t - {1'b0, r_den}) : step_t;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_den <= i_req.den;
            r_sat <= (i_req.num >= i_req.den);
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= step_r[CNT_W-1:0];
            r_quo <= {r_quo[GREY_W-2:0], step_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_sat ? {GREY_W{1'b1}} : r_quo;

endmodule

`default_nettype wire

// ===== rtl/dhe_checker.sv =====
`default_nettype none

module dhe_checker import dhe_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [BGRA_W-1:0] i_out_bgra
);

    // A pending result beat stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // Ready drops after every accepted beat while the sequencer works on it
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready high right after an accepted beat");

    // Alpha is always opaque
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_bgra[31:24] == ALPHA_FULL))
        else $error("alpha byte not opaque");

    // Grey replicated into B, G and R
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_bgra[7:0] == i_out_bgra[15:8])
                        && (i_out_bgra[15:8] == i_out_bgra[23:16]))
        else $error("color bytes differ");

endmodule

bind depth_histogram_equalizer_core dhe_checker u_dhe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_bgra  (o_pix.pixel_bgra)
);

`default_nettype wire

// ===== verif/tb_depth_histogram_equalizer_core.sv =====
`default_nettype none

module tb_depth_histogram_equalizer_core;
    import dhe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PADDR_W-1:0] MD_ADDR  = PADDR_W'(REG_BIN_LIMIT) << 2;
    localparam logic [BGRA_W-1:0]  PX_BLACK = {ALPHA_FULL, 24'h00_0000};
    localparam logic [BGRA_W-1:0]  PX_WHITE = {ALPHA_FULL, 24'hFF_FFFF};
    localparam int                 RAND_BEATS = 1050;

    typedef struct packed {
        logic [BGRA_W-1:0] bgra;
        logic              last_pixel;
    } px_t;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic              req;
        logic [15:0]       val;     // depth, or bin limit for a register write
        logic              lst;
        logic              typed;
        logic [BGRA_W-1:0] bgra;
    } row_t;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    dhe_in_if  in_bus ();
    dhe_out_if out_bus ();

    depth_histogram_equalizer_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (in_bus),
        .o_pix   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: bin counts / grey table, point count, pass flag, register
    logic [CNT_W-1:0] bin_cnt [BINS];
    logic [CNT_W-1:0] point_tally;
    bit               pass_open;
    logic [MD_W-1:0]  md_reg;
    int               settle_cycles;

    px_t pending_px [$];
    int  err_cnt    = 0;
    int  beats_done = 0;
    bit  tx_burst   = 0;
    bit  rx_burst   = 0;

    // Directed rows: extremes, mapping mid-pass, empty histogram, out-of-range bin limit
    row_t dir_rows [29] = '{
        '{ROW_BEAT, REQ_MAP,  16'd0,     1'b0, 1'b1, PX_BLACK},
        '{ROW_BEAT, REQ_MAP,  16'hFFFF,  1'b1, 1'b1, PX_BLACK},
        '{ROW_CFG,  REQ_HIST, 16'd8,     1'b0, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_HIST, 16'd5,     1'b0, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_HIST, 16'd0,     1'b0, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_MAP,  16'd5,     1'b0, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_HIST, 16'hFFFF,  1'b0, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_HIST, 16'd3,     1'b1, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_MAP,  16'd1,     1'b0, 1'b1, PX_WHITE},
        '{ROW_BEAT, REQ_MAP,  16'd4,     1'b0, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_MAP,  16'hFFFF,  1'b0, 1'b1, PX_BLACK},
        '{ROW_BEAT, REQ_MAP,  16'd0,     1'b1, 1'b1, PX_BLACK},
        '{ROW_CFG,  REQ_HIST, 16'd0,     1'b0, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_HIST, 16'hFFFF,  1'b0, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_HIST, 16'd1,     1'b1, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_MAP,  16'hFFFF,  1'b1, 1'b1, PX_BLACK},
        '{ROW_CFG,  REQ_HIST, 16'd32767, 1'b0, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_HIST, 16'd0,     1'b1, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_MAP,  16'd16383, 1'b1, 1'b1, PX_BLACK},
        '{ROW_CFG,  REQ_HIST, 16'd16384, 1'b0, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_HIST, 16'd16383, 1'b0, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_HIST, 16'hFFFF,  1'b0, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_HIST, 16'd1,     1'b1, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_MAP,  16'd1,     1'b0, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_MAP,  16'd16383, 1'b0, 1'b1, PX_BLACK},
        '{ROW_BEAT, REQ_MAP,  16'd8000,  1'b1, 1'b0, PX_BLACK},
        '{ROW_CFG,  REQ_HIST, 16'd1,     1'b0, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_HIST, 16'd7,     1'b1, 1'b0, PX_BLACK},
        '{ROW_BEAT, REQ_MAP,  16'd7,     1'b1, 1'b1, PX_BLACK}
    };

    // Effective bin count: 0 acts as 1, above BINS acts as BINS
    function automatic int bins_in_use();
        int m;
        m = int'(md_reg);
        if (m < 1)
            m = 1;
        if (m > BINS)
            m = BINS;
        return m;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
    endfunction

    // Running sum over bins 1..m-1, then grey = floor(256*(n-c)/n), capped at 255
    function automatic void build_grey_table();
        int               m;
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] c;
        longint unsigned  g;
        m = bins_in_use();
        n = point_tally;
        for (int i = 1; i < m; i++)
            bin_cnt[i] = sat_inc(bin_cnt[i], bin_cnt[i-1]);
        if (n == '0)
            return;
        for (int i = 1; i < m; i++) begin
            c = bin_cnt[i];
            if (c > n)
                c = n;
            g = (64'd256 * longint'(n - c)) / longint'(n);
            if (g > 255)
                g = 255;
            bin_cnt[i] = CNT_W'(g);
        end
    endfunction

    // One accepted beat; returns 1 when it yields a pixel
    function automatic bit model_beat(input logic req, input logic [DEPTH_W-1:0] raw,
                                      input logic lst, output px_t res);
        int                m;
        int                d;
        logic [GREY_W-1:0] g;
        m = bins_in_use();
        d = (int'(raw) >= m) ? m - 1 : int'(raw);
        res = '0;
        settle_cycles = 16;
        if (req == REQ_HIST) begin
            if (!pass_open) begin
                for (int i = 0; i < BINS; i++)
                    bin_cnt[i] = '0;
                point_tally = '0;
                pass_open = 1'b1;
                settle_cycles += BINS;
            end
            if (d != 0) begin
                bin_cnt[d] = sat_inc(bin_cnt[d], CNT_W'(1));
                point_tally = sat_inc(point_tally, CNT_W'(1));
            end
            if (lst) begin
                build_grey_table();
                pass_open = 1'b0;
                settle_cycles += 13 * m;
            end
            return 1'b0;
        end
        g = (d != 0) ? bin_cnt[d][GREY_W-1:0] : '0;
        res.bgra = {ALPHA_FULL, g, g, g};
        res.last_pixel = lst;
        return 1'b1;
    endfunction

    // Mostly small tables; the largest ones live in the directed part
    function automatic logic [MD_W-1:0] rand_bin_limit();
        case ($urandom_range(0, 9))
            0: return MD_W'(0);
            1: return MD_W'(1);
            2: return MD_W'(2);
            3: return MD_W'($urandom_range(65, 1024));
            default: return MD_W'($urandom_range(3, 64));
        endcase
    endfunction

    function automatic logic [DEPTH_W-1:0] rand_depth(input int m);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return DEPTH_W'($urandom_range(0, 65535));
            2: return DEPTH_W'(m - 1 + $urandom_range(0, 1));
            default: return DEPTH_W'($urandom_range(0, m - 1));
        endcase
    endfunction

    // Drive one beat and hold it until accepted
    task automatic send_beat(input logic req, input logic [DEPTH_W-1:0] dep, input logic lst,
                             input bit typed, input logic [BGRA_W-1:0] typed_bgra);
        int  gap;
        px_t res;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap != 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid    <= 1'b1;
        in_bus.req_type <= req;
        in_bus.depth    <= dep;
        in_bus.last     <= lst;
        do @(posedge i_clk); while (!(in_bus.valid && in_bus.ready));
        beats_done++;
        if (model_beat(req, dep, lst, res)) begin
            if (typed) begin
                res.bgra = typed_bgra;
                res.last_pixel = lst;
            end
            pending_px.push_back(res);
        end
    endtask

    // Stop sending, drain every pixel, then let table work finish
    task automatic wait_idle();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge i_clk);
        repeat (settle_cycles) @(posedge i_clk);
        settle_cycles = 0;
    endtask

    // APB write of the bin limit followed by a read-back
    task automatic cfg_write(input logic [MD_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MD_ADDR;
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        md_reg = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DW'(value)) begin
            $error("prdata: expected %h, got %h", APB_DW'(value), prdata);
            err_cnt++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #100ms;
        $display("TB_ERROR");
        $finish;
    end

    // Output side: random back-pressure, with occasional runs of none
    initial begin : rx_side
        int stall;
        out_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 31) == 0)
                rx_burst = ~rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_bus.valid && out_bus.ready));
        end
    end

    // Pixel checker: each beat against the oldest expected pixel
    always @(posedge i_clk) begin : px_check
        px_t want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_px.size() == 0) begin
                $error("pixel_bgra: expected none, got %h", out_bus.pixel_bgra);
                err_cnt++;
            end else begin
                want = pending_px.pop_front();
                if (out_bus.pixel_bgra !== want.bgra) begin
                    $error("pixel_bgra: expected %h, got %h", want.bgra, out_bus.pixel_bgra);
                    err_cnt++;
                end
                if (out_bus.last_pixel !== want.last_pixel) begin
                    $error("last_pixel: expected %b, got %b", want.last_pixel,
                           out_bus.last_pixel);
                    err_cnt++;
                end
            end
        end
    end

    // Stimulus
    initial begin : stim
        int kind;
        int k;
        int m;
        in_bus.valid    = 1'b0;
        in_bus.req_type = REQ_HIST;
        in_bus.depth    = '0;
        in_bus.last     = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;

        for (int i = 0; i < BINS; i++)
            bin_cnt[i] = '0;
        point_tally   = '0;
        pass_open     = 1'b0;
        md_reg        = MD_RESET;
        settle_cycles = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(dir_rows[r].val[MD_W-1:0]);
            end else begin
                send_beat(dir_rows[r].req, dir_rows[r].val, dir_rows[r].lst,
                          dir_rows[r].typed, dir_rows[r].bgra);
            end
        end

        // Random frames: histogram pass then mapping pass, with some broken ones
        while (beats_done < $size(dir_rows) + RAND_BEATS) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                wait_idle();
                cfg_write(rand_bin_limit());
            end
            kind = $urandom_range(0, 9);
            k = $urandom_range(4, 40);
            m = bins_in_use();
            // kind 0: no new table; kind 1: histogram pass without its last beat
            if (kind != 0) begin
                for (int p = 0; p < k; p++) begin
                    if ($urandom_range(0, 15) == 0)
                        send_beat(REQ_MAP, rand_depth(m), 1'($urandom_range(0, 1)),
                                  1'b0, PX_BLACK);
                    send_beat(REQ_HIST, rand_depth(m), (kind != 1) && (p == k - 1),
                              1'b0, PX_BLACK);
                end
                // bin limit moved between the two passes
                if ($urandom_range(0, 4) == 0) begin
                    wait_idle();
                    cfg_write(rand_bin_limit());
                    m = bins_in_use();
                end
            end
            for (int p = 0; p < k; p++)
                send_beat(REQ_MAP, rand_depth(m), p == k - 1, 1'b0, PX_BLACK);
        end

        wait_idle();
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
